/* rtl/acs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types, codes and the microcode ROM of the accumulator CPU step block.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam logic [15:0] StartPcRst = 16'hF000;

  // Configuration register index, taken from paddr[2].
  localparam logic RegStartPc = 1'b0;

  // Item modes.
  localparam logic [1:0] ModeWr = 2'd0;
  localparam logic [1:0] ModeEx = 2'd1;
  localparam logic [1:0] ModeRd = 2'd2;

  // Opcodes (high nibble of the first instruction byte).
  localparam logic [3:0] OpHlt = 4'h0;
  localparam logic [3:0] OpLda = 4'h2;
  localparam logic [3:0] OpSta = 4'h3;
  localparam logic [3:0] OpLdi = 4'h4;
  localparam logic [3:0] OpJmp = 4'h8;
  localparam logic [3:0] OpAdd = 4'hC;
  localparam logic [3:0] OpMul = 4'hE;

  typedef enum logic [1:0] {
    STATUS_RUN = 2'd0,
    STATUS_HLT = 2'd1,
    STATUS_BAD = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ASEL_PC    = 3'd0,
    ASEL_PC1   = 3'd1,
    ASEL_PC2   = 3'd2,
    ASEL_OPND  = 3'd3,
    ASEL_OPND1 = 3'd4,
    ASEL_IN    = 3'd5
  } addr_sel_e;

  typedef enum logic [1:0] {
    WSEL_IN     = 2'd0,
    WSEL_ACC_LO = 2'd1,
    WSEL_ACC_HI = 2'd2
  } wd_sel_e;

  typedef enum logic [2:0] {
    ACC_KEEP = 3'd0,
    ACC_OPND = 3'd1,
    ACC_WORD = 3'd2,
    ACC_ADD  = 3'd3,
    ACC_MUL  = 3'd4
  } acc_op_e;

  typedef enum logic [1:0] {
    PC_KEEP = 2'd0,
    PC_INC  = 2'd1,
    PC_OPND = 2'd2
  } pc_op_e;

  typedef enum logic [1:0] {
    NXT_SEQ          = 2'd0,
    NXT_FIN          = 2'd1,
    NXT_DISPATCH     = 2'd2,
    NXT_FIN_IF_HALTED = 2'd3
  } nxt_e;

  typedef struct packed {
    addr_sel_e addr_sel;
    wd_sel_e   wd_sel;
    logic      re;
    logic      we;
    logic      ld_op;
    logic      ld_hi;
    logic      ld_lo;
    logic      ld_wlo;
    logic      rd_out;
    acc_op_e   acc_op;
    pc_op_e    pc_op;
    logic      set_st;
    status_e   st_val;
    nxt_e      nxt;
  } ctrl_t;

  typedef struct packed {
    logic       halted;
    logic [3:0] op;
  } dp_stat_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] pc;
    logic [15:0] acc;
    status_e     status;
  } res_t;

  localparam ctrl_t CtrlNop = '{
    addr_sel: ASEL_PC,
    wd_sel:   WSEL_IN,
    re:       1'b0,
    we:       1'b0,
    ld_op:    1'b0,
    ld_hi:    1'b0,
    ld_lo:    1'b0,
    ld_wlo:   1'b0,
    rd_out:   1'b0,
    acc_op:   ACC_KEEP,
    pc_op:    PC_KEEP,
    set_st:   1'b0,
    st_val:   STATUS_RUN,
    nxt:      NXT_SEQ
  };

  // Microprogram addresses.
  localparam int unsigned UpcW = 5;
  localparam logic [UpcW-1:0] UpcWr   = 5'd0;
  localparam logic [UpcW-1:0] UpcRd0  = 5'd1;
  localparam logic [UpcW-1:0] UpcRd1  = 5'd2;
  localparam logic [UpcW-1:0] UpcNop  = 5'd3;
  localparam logic [UpcW-1:0] UpcF0   = 5'd4;
  localparam logic [UpcW-1:0] UpcF1   = 5'd5;
  localparam logic [UpcW-1:0] UpcF2   = 5'd6;
  localparam logic [UpcW-1:0] UpcF3   = 5'd7;
  localparam logic [UpcW-1:0] UpcHlt  = 5'd8;
  localparam logic [UpcW-1:0] UpcBad  = 5'd9;
  localparam logic [UpcW-1:0] UpcLdi  = 5'd10;
  localparam logic [UpcW-1:0] UpcJmp  = 5'd11;
  localparam logic [UpcW-1:0] UpcLda0 = 5'd12;
  localparam logic [UpcW-1:0] UpcLda1 = 5'd13;
  localparam logic [UpcW-1:0] UpcLda2 = 5'd14;
  localparam logic [UpcW-1:0] UpcAdd0 = 5'd15;
  localparam logic [UpcW-1:0] UpcAdd1 = 5'd16;
  localparam logic [UpcW-1:0] UpcAdd2 = 5'd17;
  localparam logic [UpcW-1:0] UpcMul0 = 5'd18;
  localparam logic [UpcW-1:0] UpcMul1 = 5'd19;
  localparam logic [UpcW-1:0] UpcMul2 = 5'd20;
  localparam logic [UpcW-1:0] UpcSta0 = 5'd21;
  localparam logic [UpcW-1:0] UpcSta1 = 5'd22;

  function automatic logic [UpcW-1:0] mode_entry(logic [1:0] mode);
    logic [UpcW-1:0] e;
    case (mode)
      ModeWr:  e = UpcWr;
      ModeEx:  e = UpcF0;
      ModeRd:  e = UpcRd0;
      default: e = UpcNop;
    endcase
    return e;
  endfunction

  function automatic logic [UpcW-1:0] op_entry(logic [3:0] op);
    logic [UpcW-1:0] e;
    case (op)
      OpHlt:   e = UpcHlt;
      OpLda:   e = UpcLda0;
      OpSta:   e = UpcSta0;
      OpLdi:   e = UpcLdi;
      OpJmp:   e = UpcJmp;
      OpAdd:   e = UpcAdd0;
      OpMul:   e = UpcMul0;
      default: e = UpcBad;
    endcase
    return e;
  endfunction

  function automatic ctrl_t ucode(logic [UpcW-1:0] upc);
    ctrl_t c;
    c = CtrlNop;
    case (upc)
      UpcWr: begin
        c.addr_sel = ASEL_IN;
        c.we       = 1'b1;
        c.wd_sel   = WSEL_IN;
        c.nxt      = NXT_FIN;
      end
      UpcRd0: begin
        c.addr_sel = ASEL_IN;
        c.re       = 1'b1;
      end
      UpcRd1: begin
        c.rd_out = 1'b1;
        c.nxt    = NXT_FIN;
      end
      UpcNop: begin
        c.nxt = NXT_FIN;
      end
      UpcF0: begin
        c.addr_sel = ASEL_PC;
        c.re       = 1'b1;
        c.nxt      = NXT_FIN_IF_HALTED;
      end
      UpcF1: begin
        c.addr_sel = ASEL_PC1;
        c.re       = 1'b1;
        c.ld_op    = 1'b1;
      end
      UpcF2: begin
        c.addr_sel = ASEL_PC2;
        c.re       = 1'b1;
        c.ld_hi    = 1'b1;
      end
      UpcF3: begin
        c.ld_lo = 1'b1;
        c.nxt   = NXT_DISPATCH;
      end
      UpcHlt: begin
        c.set_st = 1'b1;
        c.st_val = STATUS_HLT;
        c.nxt    = NXT_FIN;
      end
      UpcBad: begin
        c.set_st = 1'b1;
        c.st_val = STATUS_BAD;
        c.nxt    = NXT_FIN;
      end
      UpcLdi: begin
        c.acc_op = ACC_OPND;
        c.pc_op  = PC_INC;
        c.nxt    = NXT_FIN;
      end
      UpcJmp: begin
        c.pc_op = PC_OPND;
        c.nxt   = NXT_FIN;
      end
      UpcLda0, UpcAdd0, UpcMul0: begin
        c.addr_sel = ASEL_OPND;
        c.re       = 1'b1;
      end
      UpcLda1, UpcAdd1, UpcMul1: begin
        c.addr_sel = ASEL_OPND1;
        c.re       = 1'b1;
        c.ld_wlo   = 1'b1;
      end
      UpcLda2: begin
        c.acc_op = ACC_WORD;
        c.pc_op  = PC_INC;
        c.nxt    = NXT_FIN;
      end
      UpcAdd2: begin
        c.acc_op = ACC_ADD;
        c.pc_op  = PC_INC;
        c.nxt    = NXT_FIN;
      end
      UpcMul2: begin
        c.acc_op = ACC_MUL;
        c.pc_op  = PC_INC;
        c.nxt    = NXT_FIN;
      end
      UpcSta0: begin
        c.addr_sel = ASEL_OPND;
        c.we       = 1'b1;
        c.wd_sel   = WSEL_ACC_LO;
      end
      UpcSta1: begin
        c.addr_sel = ASEL_OPND1;
        c.we       = 1'b1;
        c.wd_sel   = WSEL_ACC_HI;
        c.pc_op    = PC_INC;
        c.nxt      = NXT_FIN;
      end
      default: begin
        c.nxt = NXT_FIN;
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/acs_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acs_in_if / acs_out_if
// Valid/ready channels that carry the input and result words.
// ----------------------------------------------------------------------------
interface acs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] address;
  logic [7:0]  data;

  modport source (output valid, mode, address, data, input ready);
  modport sink (input valid, mode, address, data, output ready);
endinterface

interface acs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [15:0] pc;
  logic [15:0] accumulator;
  logic [1:0]  status;

  modport source (output valid, read_data, pc, accumulator, status, input ready);
  modport sink (input valid, read_data, pc, accumulator, status, output ready);
endinterface
`default_nettype wire

/* rtl/acs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module acs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     re_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/acs_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acs_seq
// Microcode sequencer: step counter, control ROM and jump logic.
// ----------------------------------------------------------------------------
module acs_seq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [1:0]       mode_i,
  input  wire acs_pkg::dp_stat_t stat_i,
  input  wire logic             out_full_i,
  output acs_pkg::ctrl_t        ctrl_o,
  output logic                  busy_o,
  output logic                  fin_o
);

  logic                      busy_q, busy_d;
  logic [acs_pkg::UpcW-1:0]  upc_q, upc_d;
  acs_pkg::ctrl_t            rom;
  logic                      fin_raw;
  logic                      hold;

  assign rom     = acs_pkg::ucode(upc_q);
  assign fin_raw = busy_q && ((rom.nxt == acs_pkg::NXT_FIN) ||
                   ((rom.nxt == acs_pkg::NXT_FIN_IF_HALTED) && stat_i.halted));
  assign hold    = fin_raw && out_full_i;

  always_comb begin
    busy_d = busy_q;
    upc_d  = upc_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        upc_d  = acs_pkg::mode_entry(mode_i);
      end
    end else if (!hold) begin
      if (fin_raw) begin
        busy_d = 1'b0;
      end else begin
        case (rom.nxt)
          acs_pkg::NXT_DISPATCH: upc_d = acs_pkg::op_entry(stat_i.op);
          default:               upc_d = upc_q + acs_pkg::UpcW'(1);
        endcase
      end
    end
  end

  always_comb begin
    ctrl_o = (busy_q && !hold) ? rom : acs_pkg::CtrlNop;
    fin_o  = fin_raw && !out_full_i;
    busy_o = busy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= '0;
    end else begin
      busy_q <= busy_d;
      upc_q  <= upc_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/acs_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acs_dp
// Datapath: byte memory with its clearing sweep, program counter,
// accumulator, status and the operand registers.
// ----------------------------------------------------------------------------
module acs_dp #(
  parameter int unsigned MemBytes = 65536
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_ld_i,
  input  wire logic [15:0]    in_addr_i,
  input  wire logic [7:0]     in_data_i,
  input  wire acs_pkg::ctrl_t ctrl_i,
  output acs_pkg::dp_stat_t   stat_o,
  output acs_pkg::res_t       res_o,
  output logic                clr_busy_o
);

  localparam int unsigned AddrW    = $clog2(MemBytes);
  localparam logic [15:0] AddrMask = 16'(MemBytes - 1);
  localparam logic [AddrW-1:0] ClrLast = AddrW'(MemBytes - 1);

  logic             clr_busy_q, clr_busy_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic [15:0]      addr_q;
  logic [7:0]       data_q;
  logic [3:0]       op_q;
  logic [15:0]      opnd_q;
  logic [7:0]       wlo_q;
  logic [15:0]      pc_q, pc_d;
  logic [15:0]      acc_q, acc_d;
  acs_pkg::status_e status_q, status_d;

  logic [15:0]      addr16;
  logic [7:0]       wd;
  logic [AddrW-1:0] ram_addr;
  logic             ram_we;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;
  logic [15:0]      word;
  logic [15:0]      prod;
  logic [15:0]      pc_inc;

  always_comb begin
    case (ctrl_i.addr_sel)
      acs_pkg::ASEL_PC:    addr16 = pc_q;
      acs_pkg::ASEL_PC1:   addr16 = pc_q + 16'd1;
      acs_pkg::ASEL_PC2:   addr16 = pc_q + 16'd2;
      acs_pkg::ASEL_OPND:  addr16 = opnd_q;
      acs_pkg::ASEL_OPND1: addr16 = opnd_q + 16'd1;
      acs_pkg::ASEL_IN:    addr16 = addr_q;
      default:             addr16 = addr_q;
    endcase
    case (ctrl_i.wd_sel)
      acs_pkg::WSEL_ACC_LO: wd = acc_q[7:0];
      acs_pkg::WSEL_ACC_HI: wd = acc_q[15:8];
      default:              wd = data_q;
    endcase
  end

  assign ram_addr  = clr_busy_q ? clr_cnt_q : addr16[AddrW-1:0];
  assign ram_we    = clr_busy_q || ctrl_i.we;
  assign ram_wdata = clr_busy_q ? 8'd0 : wd;

  acs_ram #(
    .Width (8),
    .Depth (MemBytes)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (ctrl_i.re),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign word   = {ram_rdata, wlo_q};
  assign prod   = 16'(acc_q * word);
  assign pc_inc = (pc_q + 16'd3) & AddrMask;

  always_comb begin
    case (ctrl_i.acc_op)
      acs_pkg::ACC_OPND: acc_d = opnd_q;
      acs_pkg::ACC_WORD: acc_d = word;
      acs_pkg::ACC_ADD:  acc_d = acc_q + word;
      acs_pkg::ACC_MUL:  acc_d = prod;
      default:           acc_d = acc_q;
    endcase
    case (ctrl_i.pc_op)
      acs_pkg::PC_INC:  pc_d = pc_inc;
      acs_pkg::PC_OPND: pc_d = opnd_q;
      default:          pc_d = pc_q;
    endcase
    status_d = ctrl_i.set_st ? ctrl_i.st_val : status_q;
  end

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == ClrLast) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      pc_q       <= acs_pkg::StartPcRst;
      acc_q      <= '0;
      status_q   <= acs_pkg::STATUS_RUN;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
      pc_q       <= pc_d;
      acc_q      <= acc_d;
      status_q   <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ld_i) begin
      addr_q <= in_addr_i;
      data_q <= in_data_i;
    end
    if (ctrl_i.ld_op) begin
      op_q <= ram_rdata[7:4];
    end
    if (ctrl_i.ld_hi) begin
      opnd_q[15:8] <= ram_rdata;
    end
    if (ctrl_i.ld_lo) begin
      opnd_q[7:0] <= ram_rdata;
    end
    if (ctrl_i.ld_wlo) begin
      wlo_q <= ram_rdata;
    end
  end

  always_comb begin
    stat_o.halted    = (status_q != acs_pkg::STATUS_RUN);
    stat_o.op        = op_q;
    res_o.read_data  = ctrl_i.rd_out ? ram_rdata : 8'd0;
    res_o.pc         = pc_d;
    res_o.acc        = acc_d;
    res_o.status     = status_d;
    clr_busy_o       = clr_busy_q;
  end

endmodule
`default_nettype wire

/* rtl/accumulator_cpu_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accumulator_cpu_step
// Small 16-bit accumulator processor with a byte memory; each input word
// writes a byte, reads a byte, executes one instruction or does nothing.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake        Contents
//  in_i     in   valid/ready      mode, address, data
//  out_o    out  valid/ready      read_data, pc, accumulator, status
//  apb      in   psel/penable     start_pc at offset 0, pready tied high
//
// Write, read and execute words each run as a sequence of microcode steps;
// every memory access goes through the one RAM port. After reset the memory
// is cleared byte by byte, during which no word is accepted; configuration
// writes are taken at any time.
// A finished result waits in the output register; the sequencer stalls on
// its last step only when a second result would overwrite it.
// ----------------------------------------------------------------------------
module accumulator_cpu_step #(
  parameter int unsigned MemBytes = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  acs_in_if.sink           in_i,
  acs_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic              accept;
  logic              seq_busy;
  logic              seq_fin;
  logic              clr_busy;
  logic              out_full;
  acs_pkg::ctrl_t    ctrl;
  acs_pkg::dp_stat_t dp_stat;
  acs_pkg::res_t     res;

  logic              out_valid_q, out_valid_d;
  acs_pkg::res_t     out_res_q;
  logic [15:0]       start_pc_q, start_pc_d;
  logic              cfg_wr;

  assign in_i.ready = !seq_busy && !clr_busy;
  assign accept     = in_i.valid && in_i.ready;
  assign out_full   = out_valid_q && !out_o.ready;

  acs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .mode_i     (in_i.mode),
    .stat_i     (dp_stat),
    .out_full_i (out_full),
    .ctrl_o     (ctrl),
    .busy_o     (seq_busy),
    .fin_o      (seq_fin)
  );

  acs_dp #(
    .MemBytes (MemBytes)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ld_i    (accept),
    .in_addr_i  (in_i.address),
    .in_data_i  (in_i.data),
    .ctrl_i     (ctrl),
    .stat_o     (dp_stat),
    .res_o      (res),
    .clr_busy_o (clr_busy)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (seq_fin) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_fin) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_data   = out_res_q.read_data;
  assign out_o.pc          = out_res_q.pc;
  assign out_o.accumulator = out_res_q.acc;
  assign out_o.status      = 2'(out_res_q.status);

  // The start_pc register only matters for readback, since reset restores
  // both it and the program counter to the same value.
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == acs_pkg::RegStartPc);

  always_comb begin
    start_pc_d = start_pc_q;
    if (cfg_wr) begin
      start_pc_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pc_q <= acs_pkg::StartPcRst;
    end else begin
      start_pc_q <= start_pc_d;
    end
  end

  assign prdata = (paddr[2] == acs_pkg::RegStartPc) ? {16'd0, start_pc_q} : 32'd0;
  assign pready = 1'b1;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_full |-> !seq_fin)
    else $error("result finished while output register is still full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !seq_busy)
    else $error("sequencer active during memory clearing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> seq_busy)
    else $error("accepted word did not start the sequencer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_stat.halted |=> dp_stat.halted)
    else $error("machine left the halted state without reset");

endmodule
`default_nettype wire
